FILE: src/mic_pkg.sv
// Types, constants and control structs shared by the multiset intersection counter.
package mic_pkg;

  // TABLE_ENTRIES must be a power of two: the home slot is the low bits of the hash.
  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned COUNT_BITS    = 16;
  localparam int unsigned KEY_BITS      = 32;
  localparam int unsigned IDX_BITS      = $clog2(TABLE_ENTRIES);
  localparam int unsigned SLOT_BITS     = KEY_BITS + COUNT_BITS;

  localparam logic [KEY_BITS-1:0]   HASH_MULT = 32'd2654435761;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [IDX_BITS-1:0]   LAST_STEP = IDX_BITS'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_PROBE = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    STAT_STORED  = 3'd0,
    STAT_MATCHED = 3'd1,
    STAT_NOMATCH = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_CLEARED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_LOOKUP,
    ST_COMPARE
  } state_e;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] element;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] match_value;
  } out_item_t;

  typedef struct packed {
    logic    latch;
    logic    hash_en;
    logic    step;
    logic    wr_new;
    logic    wr_inc;
    logic    wr_dec;
    logic    clr_valid;
    logic    res_valid;
    status_e res_status;
  } mic_cmd_t;

  typedef struct packed {
    logic is_load;
    logic is_probe;
    logic is_clear;
    logic slot_valid;
    logic key_match;
    logic count_zero;
    logic count_max;
    logic walk_last;
  } mic_sts_t;

endpackage

FILE: src/mic_ram.sv
// Generic single-port-write, registered-read RAM.
module mic_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/mic_datapath.sv
// Datapath: item registers, hash, probe index, valid bits, slot memory and result register.
module mic_datapath
  import mic_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  item_i,
  input  mic_cmd_t  cmd_i,
  output mic_sts_t  sts_o,
  output logic      done_o,
  output out_item_t result_o
);

  logic [1:0]                func_q;
  logic [KEY_BITS-1:0]       key_q;
  logic [IDX_BITS-1:0]       idx_q, idx_d;
  logic [IDX_BITS-1:0]       step_q;
  logic [TABLE_ENTRIES-1:0]  valid_q;
  logic                      done_q;
  out_item_t                 res_q;

  logic [KEY_BITS-1:0]       prod;
  logic [KEY_BITS-1:0]       fold;
  logic [SLOT_BITS-1:0]      rdata;
  logic [SLOT_BITS-1:0]      wdata;
  logic [KEY_BITS-1:0]       rd_key;
  logic [COUNT_BITS-1:0]     rd_count;
  logic                      we;

  assign prod  = key_q * HASH_MULT;
  assign fold  = prod ^ (prod >> 16);
  assign idx_d = cmd_i.hash_en ? fold[IDX_BITS-1:0] : idx_q + IDX_BITS'(1);

  assign rd_key   = rdata[SLOT_BITS-1:COUNT_BITS];
  assign rd_count = rdata[COUNT_BITS-1:0];

  always_comb begin
    wdata = {key_q, COUNT_ONE};
    if (cmd_i.wr_inc) begin
      wdata = {rd_key, rd_count + COUNT_ONE};
    end else if (cmd_i.wr_dec) begin
      wdata = {rd_key, rd_count - COUNT_ONE};
    end
  end

  assign we = cmd_i.wr_new | cmd_i.wr_inc | cmd_i.wr_dec;

  mic_ram #(
    .WIDTH(SLOT_BITS),
    .DEPTH(TABLE_ENTRIES)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(idx_q),
    .wdata_i(wdata),
    .raddr_i(idx_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= item_i.func;
      key_q  <= item_i.element;
    end
    if (cmd_i.hash_en || cmd_i.step) begin
      idx_q <= idx_d;
    end
    if (cmd_i.hash_en) begin
      step_q <= '0;
    end else if (cmd_i.step) begin
      step_q <= step_q + IDX_BITS'(1);
    end
    if (cmd_i.res_valid) begin
      res_q.status      <= cmd_i.res_status;
      res_q.match_value <= (func_q == FUNC_CLEAR) ? '0 : key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.res_valid;
      if (cmd_i.clr_valid) begin
        valid_q <= '0;
      end else if (cmd_i.wr_new) begin
        valid_q[idx_q] <= 1'b1;
      end
    end
  end

  assign sts_o.is_load    = (func_q == FUNC_LOAD);
  assign sts_o.is_probe   = (func_q == FUNC_PROBE);
  assign sts_o.is_clear   = (func_q == FUNC_CLEAR);
  assign sts_o.slot_valid = valid_q[idx_q];
  assign sts_o.key_match  = (rd_key == key_q);
  assign sts_o.count_zero = (rd_count == '0);
  assign sts_o.count_max  = (rd_count == COUNT_MAX);
  assign sts_o.walk_last  = (step_q == LAST_STEP);

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

FILE: src/mic_ctrl.sv
// Controller state machine: accept, hash, probe walk and result issue.
module mic_ctrl
  import mic_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  mic_sts_t sts_i,
  output logic     busy,
  output mic_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '{default: '0, res_status: STAT_NOMATCH};
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_HASH;
        end
      end
      ST_HASH: begin
        if (sts_i.is_clear) begin
          cmd_o.clr_valid  = 1'b1;
          cmd_o.res_valid  = 1'b1;
          cmd_o.res_status = STAT_CLEARED;
          state_d          = ST_IDLE;
        end else if (sts_i.is_load || sts_i.is_probe) begin
          cmd_o.hash_en = 1'b1;
          state_d       = ST_LOOKUP;
        end else begin
          cmd_o.res_valid = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_LOOKUP: begin
        if (sts_i.slot_valid) begin
          state_d = ST_COMPARE;
        end else begin
          cmd_o.res_valid = 1'b1;
          if (sts_i.is_load) begin
            cmd_o.wr_new     = 1'b1;
            cmd_o.res_status = STAT_STORED;
          end
          state_d = ST_IDLE;
        end
      end
      ST_COMPARE: begin
        if (sts_i.key_match) begin
          cmd_o.res_valid = 1'b1;
          if (sts_i.is_load) begin
            cmd_o.wr_inc     = !sts_i.count_max;
            cmd_o.res_status = STAT_STORED;
          end else if (!sts_i.count_zero) begin
            cmd_o.wr_dec     = 1'b1;
            cmd_o.res_status = STAT_MATCHED;
          end
          state_d = ST_IDLE;
        end else if (sts_i.walk_last) begin
          cmd_o.res_valid  = 1'b1;
          cmd_o.res_status = sts_i.is_load ? STAT_FULL : STAT_NOMATCH;
          state_d          = ST_IDLE;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = ST_LOOKUP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

FILE: src/multiset_intersection_counter.sv
// Top level of the multiset intersection counter: controller plus datapath.
//
// Usage: raise start with item_i while busy is low; the item is taken at that edge.
// item_i.func selects load (count one element of the first set), probe (match one
// element of the second set against the counts) or clear (empty the table).
// Every item yields exactly one result: done_o is high for one cycle and
// result_o carries the status and the echoed element (zero for clear) in that
// cycle. The receiver cannot stall; the result must be taken when shown.
// Clear and the unused func code finish in the hash state. Load and probe pass the
// accept and hash states, then walk the slots in linear probe order, each slot
// visited in a lookup state (one memory read) and a compare state; a walk that
// ends on an empty slot finishes in lookup. The walk visits at most TABLE_ENTRIES
// slots; the slot memory read port sets the per-slot cost. busy stays high from
// accept until the cycle done_o rises; a new item may be started while done_o
// is high. Reset empties the table at once (valid bits clear) and idles.
module multiset_intersection_counter
  import mic_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item_i,
  output logic      done_o,
  output out_item_t result_o
);

  mic_cmd_t cmd;
  mic_sts_t sts;

  mic_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .sts_i (sts),
    .busy  (busy),
    .cmd_o (cmd)
  );

  mic_datapath u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .done_o  (done_o),
    .result_o(result_o)
  );

endmodule

FILE: dv/tb_multiset_intersection_counter.sv
// Testbench for the multiset intersection counter: directed and random items.
module tb_multiset_intersection_counter;
  import mic_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned LIMIT = 5_000_000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  item_i = '0;
  logic      done_o;
  out_item_t result_o;

  logic [TABLE_ENTRIES-1:0] tbl_valid = '0;
  logic [KEY_BITS-1:0]      tbl_key [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0]    tbl_count [TABLE_ENTRIES];

  out_item_t   awaited_results [$];
  out_item_t   want_res;
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;
  int          idle_pct = 0;

  multiset_intersection_counter dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [IDX_BITS-1:0] home_index(logic [KEY_BITS-1:0] key);
    logic [KEY_BITS-1:0] h;
    h = key * 32'd2654435761;
    h = h ^ (h >> 16);
    return h[IDX_BITS-1:0];
  endfunction

  function automatic out_item_t apply_to_table(in_item_t it);
    out_item_t           r;
    logic [KEY_BITS-1:0] key;
    logic [IDX_BITS-1:0] idx;
    logic [IDX_BITS-1:0] pos;
    logic                hit;
    logic                empty_seen;
    int                  n;
    key = it.element;
    r.status = STAT_NOMATCH;
    r.match_value = it.element;
    hit = 1'b0;
    empty_seen = 1'b0;
    pos = '0;
    idx = home_index(key);
    for (n = 0; n < int'(TABLE_ENTRIES) && !hit && !empty_seen; n++) begin
      if (!tbl_valid[idx]) begin
        empty_seen = 1'b1;
        pos = idx;
      end else if (tbl_key[idx] == key) begin
        hit = 1'b1;
        pos = idx;
      end else begin
        idx = idx + 1'b1;
      end
    end
    case (it.func)
      FUNC_LOAD: begin
        if (hit) begin
          if (tbl_count[pos] != COUNT_MAX) tbl_count[pos] = tbl_count[pos] + 1'b1;
          r.status = STAT_STORED;
        end else if (empty_seen) begin
          tbl_valid[pos] = 1'b1;
          tbl_key[pos] = key;
          tbl_count[pos] = COUNT_BITS'(1);
          r.status = STAT_STORED;
        end else begin
          r.status = STAT_FULL;
        end
      end
      FUNC_PROBE: begin
        if (hit && tbl_count[pos] != '0) begin
          tbl_count[pos] = tbl_count[pos] - 1'b1;
          r.status = STAT_MATCHED;
        end
      end
      FUNC_CLEAR: begin
        tbl_valid = '0;
        r.status = STAT_CLEARED;
        r.match_value = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("MISMATCH %s: got %h, want %h", what, got, want);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with no item pending", result_o.match_value, '0);
      end else begin
        want_res = awaited_results.pop_front();
        if (result_o.status !== want_res.status)
          report_mismatch("status", 32'(result_o.status), 32'(want_res.status));
        if (result_o.match_value !== want_res.match_value)
          report_mismatch("match_value", result_o.match_value, want_res.match_value);
      end
    end
  end

  task automatic send_item(logic [1:0] func, logic [31:0] element);
    in_item_t it;
    int       gap;
    it.func = func;
    it.element = element;
    gap = 0;
    while (gap < 20 && int'($urandom_range(99)) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    awaited_results.insert(awaited_results.size(), apply_to_table(it));
  endtask

  function automatic logic [31:0] rand_element();
    case ($urandom_range(3))
      0: return 32'($urandom_range(15)) - 32'd8;
      1: return $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                                  : 32'h7FFF_FFFF - $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed_ops();
    idle_pct = 0;
    send_item(FUNC_LOAD, 32'h8000_0000);
    send_item(FUNC_LOAD, 32'h7FFF_FFFF);
    send_item(FUNC_LOAD, 32'h0000_0000);
    send_item(FUNC_LOAD, 32'hFFFF_FFFF);
    send_item(FUNC_LOAD, 32'hFFFF_FFFF);
    send_item(FUNC_PROBE, 32'h8000_0000);
    send_item(FUNC_PROBE, 32'h8000_0000);
    send_item(FUNC_PROBE, 32'hFFFF_FFFF);
    send_item(FUNC_PROBE, 32'hFFFF_FFFF);
    send_item(FUNC_PROBE, 32'hFFFF_FFFF);
    send_item(FUNC_PROBE, 32'h0000_1234);
    send_item(FUNC_PROBE, 32'h7FFF_FFFF);
    send_item(FUNC_PROBE, 32'h0000_0000);
    send_item(FUNC_LOAD, 32'h8000_0000);
    send_item(FUNC_PROBE, 32'h8000_0000);
    send_item(FUNC_UNUSED, 32'h5555_AAAA);
    send_item(FUNC_UNUSED, 32'hAAAA_5555);
    send_item(FUNC_CLEAR, 32'hFFFF_FFFF);
    send_item(FUNC_PROBE, 32'h0000_0000);
    send_item(FUNC_LOAD, 32'h0000_0000);
    send_item(FUNC_PROBE, 32'h0000_0000);
  endtask

  task automatic test_full_table();
    int i;
    idle_pct = 23;
    send_item(FUNC_CLEAR, 32'h0);
    for (i = 0; i < int'(TABLE_ENTRIES); i++) send_item(FUNC_LOAD, 32'h1000_0000 + i * 7919);
    send_item(FUNC_LOAD, 32'h7000_0001);
    send_item(FUNC_LOAD, 32'h1000_0000);
    send_item(FUNC_PROBE, 32'h7000_0001);
    send_item(FUNC_PROBE, 32'h1000_0000);
    send_item(FUNC_PROBE, 32'h1000_0000 + (TABLE_ENTRIES - 1) * 7919);
    send_item(FUNC_CLEAR, 32'h0);
  endtask

  task automatic test_repeated_key();
    int i;
    idle_pct = 0;
    send_item(FUNC_CLEAR, 32'h0);
    for (i = 0; i < 30; i++) send_item(FUNC_LOAD, 32'h5A5A_0042);
    for (i = 0; i < 32; i++) send_item(FUNC_PROBE, 32'h5A5A_0042);
    send_item(FUNC_CLEAR, 32'h0);
  endtask

  task automatic test_random_sequences(int items, int pct);
    logic [31:0] pool [256];
    logic [1:0]  f;
    int          sent;
    int          n_keys;
    int          n_loads;
    int          n_probes;
    int          i;
    idle_pct = pct;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          f = 2'($urandom_range(3));
          send_item(f, rand_element());
          sent++;
        end
      end else begin
        n_keys = ($urandom_range(15) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 24);
        for (i = 0; i < n_keys; i++) pool[i] = rand_element();
        if ($urandom_range(4) != 0) begin
          send_item(FUNC_CLEAR, $urandom);
          sent++;
        end
        n_loads = n_keys + $urandom_range(n_keys);
        for (i = 0; i < n_loads; i++) begin
          send_item(FUNC_LOAD, (i < n_keys) ? pool[i] : pool[$urandom_range(n_keys - 1)]);
          sent++;
        end
        n_probes = $urandom_range(1, n_keys + 8);
        for (i = 0; i < n_probes; i++) begin
          if ($urandom_range(9) == 0)
            send_item(FUNC_LOAD, pool[$urandom_range(n_keys - 1)]);
          else if ($urandom_range(3) != 0)
            send_item(FUNC_PROBE, pool[$urandom_range(n_keys - 1)]);
          else
            send_item(FUNC_PROBE, rand_element());
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_ops();
    test_full_table();
    test_repeated_key();
    test_random_sequences(380, 0);
    test_random_sequences(380, 54);
    test_random_sequences(380, 23);
    test_random_sequences(380, 0);
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (2 * TABLE_ENTRIES + 16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
